// ===== hdl/ppm_pkg.sv =====
// Shared types and constants for the pseudocolor palette mapper.
package ppm_pkg;

   localparam int PIX_W     = 8;
   localparam int MODE_W    = 3;
   localparam int ADDR_W    = MODE_W + PIX_W;
   localparam int PAL_DEPTH = 1 << ADDR_W;
   localparam int RGB_W     = 3 * PIX_W;
   localparam int OUT_DEPTH = 4;
   localparam int PTR_W     = 2;
   localparam int OCC_W     = 3;

   // Palette selection codes
   typedef enum logic [MODE_W-1:0] {
      PM_GRAY     = 3'd0,
      PM_INVERTED = 3'd1,
      PM_HOT      = 3'd2,
      PM_COOL     = 3'd3,
      PM_RAINBOW  = 3'd4,
      PM_BONE     = 3'd5,
      PM_COPPER   = 3'd6,
      PM_OCEAN    = 3'd7
   } palette_mode_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } rgb_type;

   // Palette table write from the fill sequencer
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      rgb_type           data;
   } fill_wr_type;

endpackage

// ===== hdl/ppm_req_if.sv =====
// Request channel: one gray pixel word per handshake.
interface ppm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] gray;

   modport source (output valid, output gray, input ready);
   modport sink (input valid, input gray, output ready);
endinterface

// ===== hdl/ppm_rsp_if.sv =====
// Response channel: one RGB color word per handshake.
interface ppm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== hdl/ppm_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ppm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ppm_palette_gen.sv =====
// Fill sequencer: sweeps every mode and gray code once after reset and
// writes the palette table, using running quotient/remainder pairs.
module ppm_palette_gen (
   input  logic                 clock,
   input  logic                 reset,
   output ppm_pkg::fill_wr_type fill_wr,
   output logic                 fill_done
);

   logic [ppm_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic                       busy_ff, busy_in;

   // Running quotients and remainders, valid for the current gray code
   logic [9:0]  hq_ff, hq_in;     // 8g/3
   logic [1:0]  hr_ff, hr_in;
   logic [8:0]  bq_ff, bq_in;     // (g*g + 2295g)/2550
   logic [11:0] br_ff, br_in;
   logic [7:0]  oq_ff, oq_in;     // g*g/255
   logic [7:0]  orem_ff, orem_in;
   logic [7:0]  sq_ff, sq_in;     // 6g/10
   logic [3:0]  sr_ff, sr_in;
   logic [7:0]  cgq_ff, cgq_in;   // 7812g/10000
   logic [13:0] cgr_ff, cgr_in;
   logic [7:0]  cbq_ff, cbq_in;   // 4975g/10000
   logic [13:0] cbr_ff, cbr_in;

   logic [ppm_pkg::PIX_W-1:0] g;
   ppm_pkg::palette_mode_type mode;
   ppm_pkg::rgb_type          color;

   logic [11:0] bone_d;
   logic [12:0] bone_t;
   logic [9:0]  ocn_t;
   logic [2:0]  hot_t;
   logic [4:0]  sq_t;
   logic [14:0] cg_t;
   logic [14:0] cb_t;

   logic [7:0]  rb_m;
   logic [5:0]  rb_dist;
   logic [5:0]  rb_v;
   logic [7:0]  rb_x;
   logic [9:0]  hot_gm;
   logic [9:0]  hot_bm;
   logic [10:0] cu_5g;
   logic [7:0]  bone_x;

   assign g    = addr_ff[ppm_pkg::PIX_W-1:0];
   assign mode = ppm_pkg::palette_mode_type'(addr_ff[ppm_pkg::ADDR_W-1:ppm_pkg::PIX_W]);

   // Sweep counter
   always_comb begin
      addr_in = addr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         addr_in = addr_ff + 1'b1;
         if (addr_ff == {ppm_pkg::ADDR_W{1'b1}}) begin
            busy_in = 1'b0;
         end
      end
   end

   // Step each quotient/remainder pair from g to g+1
   always_comb begin
      hot_t  = {1'b0, hr_ff} + 3'd2;
      bone_d = {3'b0, g, 1'b0} + 12'd2296;
      bone_t = {1'b0, br_ff} + {1'b0, bone_d};
      ocn_t  = {2'b0, orem_ff} + {1'b0, g, 1'b1};
      sq_t   = {1'b0, sr_ff} + 5'd6;
      cg_t   = {1'b0, cgr_ff} + 15'd7812;
      cb_t   = {1'b0, cbr_ff} + 15'd4975;

      hq_in = hq_ff + 10'd2;
      hr_in = hot_t[1:0];
      if (hot_t >= 3'd3) begin
         hq_in = hq_ff + 10'd3;
         hr_in = 2'(hot_t - 3'd3);
      end

      bq_in = bq_ff;
      br_in = bone_t[11:0];
      if (bone_t >= 13'd5100) begin
         bq_in = bq_ff + 9'd2;
         br_in = 12'(bone_t - 13'd5100);
      end else if (bone_t >= 13'd2550) begin
         bq_in = bq_ff + 9'd1;
         br_in = 12'(bone_t - 13'd2550);
      end

      oq_in   = oq_ff;
      orem_in = ocn_t[7:0];
      if (ocn_t >= 10'd765) begin
         oq_in   = oq_ff + 8'd3;
         orem_in = 8'(ocn_t - 10'd765);
      end else if (ocn_t >= 10'd510) begin
         oq_in   = oq_ff + 8'd2;
         orem_in = 8'(ocn_t - 10'd510);
      end else if (ocn_t >= 10'd255) begin
         oq_in   = oq_ff + 8'd1;
         orem_in = 8'(ocn_t - 10'd255);
      end

      sq_in = sq_ff;
      sr_in = sq_t[3:0];
      if (sq_t >= 5'd10) begin
         sq_in = sq_ff + 8'd1;
         sr_in = 4'(sq_t - 5'd10);
      end

      cgq_in = cgq_ff;
      cgr_in = cg_t[13:0];
      if (cg_t >= 15'd10000) begin
         cgq_in = cgq_ff + 8'd1;
         cgr_in = 14'(cg_t - 15'd10000);
      end

      cbq_in = cbq_ff;
      cbr_in = cb_t[13:0];
      if (cb_t >= 15'd10000) begin
         cbq_in = cbq_ff + 8'd1;
         cbr_in = 14'(cb_t - 15'd10000);
      end

      // Every numerator is zero at the start of a mode
      if (g == {ppm_pkg::PIX_W{1'b1}}) begin
         hq_in   = '0;
         hr_in   = '0;
         bq_in   = '0;
         br_in   = '0;
         oq_in   = '0;
         orem_in = '0;
         sq_in   = '0;
         sr_in   = '0;
         cgq_in  = '0;
         cgr_in  = '0;
         cbq_in  = '0;
         cbr_in  = '0;
      end
   end

   // Palette entry for the current mode and gray code
   always_comb begin
      if (g < 8'd102) begin
         rb_m = g;
      end else if (g < 8'd204) begin
         rb_m = g - 8'd102;
      end else begin
         rb_m = g - 8'd204;
      end
      rb_dist = (rb_m >= 8'd51) ? 6'(rb_m - 8'd51) : 6'(8'd51 - rb_m);
      rb_v    = 6'd51 - rb_dist;
      rb_x    = {rb_v, 2'b00} + {2'b00, rb_v};

      hot_gm = hq_ff - 10'd255;
      hot_bm = {g, 2'b00} - 10'd765;
      cu_5g  = {1'b0, g, 2'b00} + {3'b000, g};
      bone_x = (bq_ff > 9'd255) ? 8'hFF : bq_ff[7:0];

      case (mode)
         ppm_pkg::PM_GRAY: begin
            color = '{red: g, green: g, blue: g};
         end
         ppm_pkg::PM_INVERTED: begin
            color = '{red: ~g, green: ~g, blue: ~g};
         end
         ppm_pkg::PM_HOT: begin
            color.red   = (g <= 8'd95) ? hq_ff[7:0] : 8'hFF;
            color.green = (g <= 8'd95) ? 8'h00 : ((g <= 8'd191) ? hot_gm[7:0] : 8'hFF);
            color.blue  = (g <= 8'd191) ? 8'h00 : hot_bm[7:0];
         end
         ppm_pkg::PM_COOL: begin
            color = '{red: g, green: ~g, blue: 8'hFF};
         end
         ppm_pkg::PM_RAINBOW: begin
            if (g < 8'd51) begin
               color = '{red: 8'hFF, green: rb_x, blue: 8'h00};
            end else if (g < 8'd102) begin
               color = '{red: rb_x, green: 8'hFF, blue: 8'h00};
            end else if (g < 8'd153) begin
               color = '{red: 8'h00, green: 8'hFF, blue: rb_x};
            end else if (g < 8'd204) begin
               color = '{red: 8'h00, green: rb_x, blue: 8'hFF};
            end else begin
               color = '{red: rb_x, green: 8'h00, blue: 8'hFF};
            end
         end
         ppm_pkg::PM_BONE: begin
            color = '{red: bone_x, green: bone_x, blue: g};
         end
         ppm_pkg::PM_COPPER: begin
            color.red   = (cu_5g[10:2] > 9'd255) ? 8'hFF : cu_5g[9:2];
            color.green = cgq_ff;
            color.blue  = cbq_ff;
         end
         default: begin
            color = '{red: oq_ff, green: g, blue: 8'd102 + sq_ff};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         busy_ff <= 1'b1;
         hq_ff   <= '0;
         hr_ff   <= '0;
         bq_ff   <= '0;
         br_ff   <= '0;
         oq_ff   <= '0;
         orem_ff <= '0;
         sq_ff   <= '0;
         sr_ff   <= '0;
         cgq_ff  <= '0;
         cgr_ff  <= '0;
         cbq_ff  <= '0;
         cbr_ff  <= '0;
      end else begin
         addr_ff <= addr_in;
         busy_ff <= busy_in;
         hq_ff   <= hq_in;
         hr_ff   <= hr_in;
         bq_ff   <= bq_in;
         br_ff   <= br_in;
         oq_ff   <= oq_in;
         orem_ff <= orem_in;
         sq_ff   <= sq_in;
         sr_ff   <= sr_in;
         cgq_ff  <= cgq_in;
         cgr_ff  <= cgr_in;
         cbq_ff  <= cbq_in;
         cbr_ff  <= cbr_in;
      end
   end

   assign fill_wr.en   = busy_ff;
   assign fill_wr.addr = addr_ff;
   assign fill_wr.data = color;
   assign fill_done    = ~busy_ff;

`ifndef SYNTHESIS
   // Once the sweep ends it stays ended until reset
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      fill_done |=> fill_done)
      else $error("palette fill restarted without reset");

   // The sweep advances by one entry every cycle while it runs
   a_sweep_step: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && busy_in) |=> (addr_ff == ppm_pkg::ADDR_W'($past(addr_ff) + 1'b1)))
      else $error("palette fill address skipped");

   // Accumulators start each mode from zero
   a_mode_start: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && g == '0) |-> (hq_ff == '0 && bq_ff == '0 && oq_ff == '0 && cgq_ff == '0))
      else $error("palette accumulators not cleared at mode start");
`endif

endmodule

// ===== hdl/pseudocolor_palette_mapper.sv =====
// Pseudocolor palette mapper: gray pixel in, palette RGB color out.
//
// Usage:
//   req_chan carries one 8-bit gray pixel word per valid/ready handshake;
//   rsp_chan returns one red/green/blue word per pixel, in order.
//   csr_wr_en/csr_wr_data select the palette (gray, inverted, hot, cool,
//   rainbow, bone, copper, ocean); write it only while no pixel is pending.
// Path and throughput:
//   An accepted pixel's table read is registered, then written into the
//   output queue, from which rsp_chan offers it. One pixel per clock is
//   sustained while rsp_chan.ready stays high; the palette table's one read
//   port, addressed by {mode, gray}, sets that rate.
// Reset:
//   The mode returns to gray. A fill sequencer then computes all 2048 table
//   entries (8 modes x 256 codes), one per cycle, so req_chan.ready stays low
//   until the fill is done. CSR writes are taken meanwhile.
// Stall:
//   A 4-word output queue absorbs results in flight; req_chan.ready drops
//   only during the fill or when the queue plus the pending table read would
//   exceed it, and it depends on registers alone, never on rsp_chan.ready.
module pseudocolor_palette_mapper (
   input  logic                           clock,
   input  logic                           reset,
   ppm_req_if.sink                        req_chan,
   ppm_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [ppm_pkg::MODE_W-1:0]     csr_wr_data
);

   ppm_pkg::palette_mode_type mode_ff, mode_in;
   ppm_pkg::fill_wr_type      fill_wr;
   logic                      fill_done;

   logic                      req_fire;
   logic                      rsp_fire;
   logic                      rd_valid_ff;
   logic [ppm_pkg::RGB_W-1:0] rd_data;

   ppm_pkg::rgb_type          fifo_mem_ff [ppm_pkg::OUT_DEPTH];
   logic [ppm_pkg::PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ppm_pkg::PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ppm_pkg::OCC_W-1:0] fifo_cnt_ff, fifo_cnt_in;
   logic [ppm_pkg::OCC_W-1:0] occupancy;
   ppm_pkg::rgb_type          head;

   // Palette register
   assign mode_in = csr_wr_en ? ppm_pkg::palette_mode_type'(csr_wr_data) : mode_ff;

   // Table fill after reset
   ppm_palette_gen u_gen (
      .clock     (clock),
      .reset     (reset),
      .fill_wr   (fill_wr),
      .fill_done (fill_done)
   );

   // Palette table: written by the fill, read once per accepted pixel
   ppm_ram #(
      .WIDTH (ppm_pkg::RGB_W),
      .DEPTH (ppm_pkg::PAL_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (fill_wr.en),
      .wr_addr (fill_wr.addr),
      .wr_data (fill_wr.data),
      .rd_en   (req_fire),
      .rd_addr ({mode_ff, req_chan.gray}),
      .rd_data (rd_data)
   );

   // Credit: pending read plus queued words never exceed the queue depth
   assign occupancy      = fifo_cnt_ff + {{(ppm_pkg::OCC_W-1){1'b0}}, rd_valid_ff};
   assign req_chan.ready = fill_done && (occupancy < ppm_pkg::OCC_W'(ppm_pkg::OUT_DEPTH));
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;

   // Output queue pointers
   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      fifo_cnt_in = fifo_cnt_ff;
      if (rd_valid_ff) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (rsp_fire) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (rd_valid_ff && !rsp_fire) begin
         fifo_cnt_in = fifo_cnt_ff + 1'b1;
      end else if (!rd_valid_ff && rsp_fire) begin
         fifo_cnt_in = fifo_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ppm_pkg::PM_GRAY;
         rd_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         mode_ff     <= mode_in;
         rd_valid_ff <= req_fire;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fifo_cnt_ff <= fifo_cnt_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         fifo_mem_ff[wr_ptr_ff] <= ppm_pkg::rgb_type'(rd_data);
      end
   end

   assign head           = fifo_mem_ff[rd_ptr_ff];
   assign rsp_chan.valid = (fifo_cnt_ff != '0);
   assign rsp_chan.red   = head.red;
   assign rsp_chan.green = head.green;
   assign rsp_chan.blue  = head.blue;

`ifndef SYNTHESIS
   // No pixel enters before the palette table is complete
   a_no_accept_in_fill: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> fill_done)
      else $error("pixel accepted during palette fill");

   // A table read result only appears for an accepted pixel
   a_read_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(req_fire))
      else $error("table read without accepted pixel");

   // Queue plus pending read stay within the queue depth
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy <= ppm_pkg::OCC_W'(ppm_pkg::OUT_DEPTH))
      else $error("output queue overflow");

   // Nothing pending means nothing offered next cycle
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (occupancy == '0) |=> !rsp_chan.valid)
      else $error("response offered with nothing pending");
`endif

endmodule

// ===== sim/pseudocolor_palette_mapper_tb.sv =====
// Self-checking testbench for the pseudocolor palette mapper: directed and random pixels.
`timescale 1ns / 100ps

module pseudocolor_palette_mapper_tb;

   localparam int RESET_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 20000;  // covers the table fill after reset
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_PIXELS  = 80;
   localparam int BURST_PIXELS   = 60;

   // One outstanding color with the context it was predicted under
   typedef struct {
      ppm_pkg::rgb_type          color;
      logic [ppm_pkg::PIX_W-1:0] gray;
      ppm_pkg::palette_mode_type mode;
   } pending_color_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [ppm_pkg::MODE_W-1:0] csr_wr_data;

   ppm_req_if req_if ();
   ppm_rsp_if rsp_if ();

   pseudocolor_palette_mapper uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pending_color_type         pending_colors[$];
   ppm_pkg::palette_mode_type active_mode;
   bit no_idle;
   int error_count;
   int pixels_sent;
   int colors_checked;
   int palette_writes;
   int idle_cycles;
   int ready_hold;

   // Clock: 10 ns period
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Gap length: mostly none or short, now and then long
   function automatic int gap_length();
      int pick;
      if (no_idle)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      else if (pick < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(4, 30);
   endfunction

   // Expected color for one gray code under one palette
   function automatic ppm_pkg::rgb_type map_gray(ppm_pkg::palette_mode_type mode,
                                                 logic [ppm_pkg::PIX_W-1:0] gray);
      int unsigned g, m, d, x, r, gr, b;
      ppm_pkg::rgb_type c;
      g = {24'b0, gray};
      case (mode)
         ppm_pkg::PM_GRAY: begin
            r = g; gr = g; b = g;
         end
         ppm_pkg::PM_INVERTED: begin
            r = 255 - g; gr = 255 - g; b = 255 - g;
         end
         ppm_pkg::PM_HOT: begin
            r  = (g <= 95) ? (8 * g) / 3 : 255;
            gr = (g <= 95) ? 0 : ((g <= 191) ? (8 * g - 765) / 3 : 255);
            b  = (g <= 191) ? 0 : 4 * g - 765;
         end
         ppm_pkg::PM_COOL: begin
            r = g; gr = 255 - g; b = 255;
         end
         ppm_pkg::PM_RAINBOW: begin
            // triangle ramp over each pair of hue sectors
            m = g % 102;
            d = (m >= 51) ? m - 51 : 51 - m;
            x = 5 * (51 - d);
            if (g < 51) begin
               r = 255; gr = x; b = 0;
            end else if (g < 102) begin
               r = x; gr = 255; b = 0;
            end else if (g < 153) begin
               r = 0; gr = 255; b = x;
            end else if (g < 204) begin
               r = 0; gr = x; b = 255;
            end else begin
               r = x; gr = 0; b = 255;
            end
         end
         ppm_pkg::PM_BONE: begin
            x = (g * g + 2295 * g) / 2550;
            if (x > 255)
               x = 255;
            r = x; gr = x; b = g;
         end
         ppm_pkg::PM_COPPER: begin
            x  = (5 * g) / 4;
            r  = (x > 255) ? 255 : x;
            gr = (7812 * g) / 10000;
            b  = (4975 * g) / 10000;
         end
         default: begin
            r  = (g * g) / 255;
            gr = g;
            b  = 102 + (6 * g) / 10;
         end
      endcase
      c.red   = r[ppm_pkg::PIX_W-1:0];
      c.green = gr[ppm_pkg::PIX_W-1:0];
      c.blue  = b[ppm_pkg::PIX_W-1:0];
      return c;
   endfunction

   function automatic void check_channel(string name, pending_color_type exp,
                                         logic [ppm_pkg::PIX_W-1:0] want,
                                         logic [ppm_pkg::PIX_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s wrong for gray %0d in %s: expected %0d, actual %0d",
                  $time, name, exp.gray, exp.mode.name(), want, got);
      end
   endfunction

   // Monitor: check returned colors first, then predict newly accepted pixels
   always @(posedge clock) begin
      pending_color_type exp;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_colors.size() == 0) begin
            error_count++;
            $display("%0t: unexpected color word, expected none, actual %0d/%0d/%0d",
                     $time, rsp_if.red, rsp_if.green, rsp_if.blue);
         end else begin
            exp = pending_colors.pop_front();
            check_channel("red", exp, exp.color.red, rsp_if.red);
            check_channel("green", exp, exp.color.green, rsp_if.green);
            check_channel("blue", exp, exp.color.blue, rsp_if.blue);
            colors_checked++;
         end
      end
      if (!reset && req_if.valid && req_if.ready) begin
         exp.gray  = req_if.gray;
         exp.mode  = active_mode;
         exp.color = map_gray(active_mode, req_if.gray);
         pending_colors.push_back(exp);
      end
   end

   // Response sink: random stalls, or always ready during a burst
   always @(posedge clock) begin
      int n;
      if (ready_hold > 0) begin
         ready_hold--;
      end else if (no_idle) begin
         rsp_if.ready <= 1'b1;
      end else begin
         n = gap_length();
         if (n == 0) begin
            rsp_if.ready <= 1'b1;
            ready_hold = $urandom_range(0, 7);
         end else begin
            rsp_if.ready <= 1'b0;
            ready_hold = n - 1;
         end
      end
   end

   // Watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles, %0d colors outstanding",
                  $time, idle_cycles, pending_colors.size());
         $display("pseudocolor_palette_mapper: mismatch");
         $finish;
      end
   end

   // Send one gray word; called and returns just after a rising edge
   task automatic send_pixel(logic [ppm_pkg::PIX_W-1:0] gray);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.gray  <= gray;
      do
         @(posedge clock);
      while (!req_if.ready);
      pixels_sent++;
   endtask

   task automatic end_burst();
      req_if.valid <= 1'b0;
   endtask

   // Palette change: only once every pending color is back
   task automatic set_palette(ppm_pkg::palette_mode_type mode);
      end_burst();
      // wait for the clock so the last accepted pixel is already queued for checking
      @(posedge clock);
      while (pending_colors.size() != 0)
         @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      active_mode = mode;
      palette_writes++;
   endtask

   // Mostly uniform codes, some on ramp breakpoints
   function automatic logic [ppm_pkg::PIX_W-1:0] random_gray();
      logic [ppm_pkg::PIX_W-1:0] edges[17] = '{0, 1, 50, 51, 95, 96, 101, 102, 152, 153,
                                               191, 192, 203, 204, 205, 254, 255};
      if ($urandom_range(0, 4) == 0)
         return edges[$urandom_range(0, 16)];
      return ppm_pkg::PIX_W'($urandom_range(0, 255));
   endfunction

   // No palette write yet: mode must come out of reset as gray
   task automatic test_reset_mode();
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'h55);
      send_pixel(8'hAA);
   endtask

   task automatic test_code_extremes();
      set_palette(ppm_pkg::PM_INVERTED);
      send_pixel(8'd0);
      send_pixel(8'd255);
      set_palette(ppm_pkg::PM_OCEAN);
      send_pixel(8'd0);
      send_pixel(8'd255);
      set_palette(ppm_pkg::PM_COOL);
      send_pixel(8'd0);
   endtask

   // Hot: edges of the three piecewise ramps
   task automatic test_hot_ramps();
      set_palette(ppm_pkg::PM_HOT);
      send_pixel(8'd95);
      send_pixel(8'd96);
      send_pixel(8'd191);
      send_pixel(8'd192);
   endtask

   // Rainbow: sector boundaries, the peak of the ramp and the top code
   task automatic test_rainbow_sectors();
      set_palette(ppm_pkg::PM_RAINBOW);
      send_pixel(8'd50);
      send_pixel(8'd51);
      send_pixel(8'd101);
      send_pixel(8'd102);
      send_pixel(8'd153);
      send_pixel(8'd204);
      send_pixel(8'd255);
   endtask

   // Bone top code and code 128, and copper red just below and at saturation
   task automatic test_bone_copper();
      set_palette(ppm_pkg::PM_BONE);
      send_pixel(8'd255);
      send_pixel(8'd128);
      set_palette(ppm_pkg::PM_COPPER);
      send_pixel(8'd204);
      send_pixel(8'd205);
   endtask

   // One random phase per palette, extremes of the mode code first
   task automatic test_random_palettes();
      ppm_pkg::palette_mode_type order[8] = '{ppm_pkg::PM_GRAY, ppm_pkg::PM_OCEAN,
                                              ppm_pkg::PM_INVERTED, ppm_pkg::PM_HOT,
                                              ppm_pkg::PM_COOL, ppm_pkg::PM_RAINBOW,
                                              ppm_pkg::PM_BONE, ppm_pkg::PM_COPPER};
      ppm_pkg::palette_mode_type tmp;
      int j;
      for (int i = 7; i > 2; i--) begin
         j = $urandom_range(2, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      foreach (order[i]) begin
         set_palette(order[i]);
         repeat (RANDOM_PIXELS) send_pixel(random_gray());
      end
   endtask

   // Full rate on both sides, no gaps at all
   task automatic test_full_rate();
      set_palette(ppm_pkg::palette_mode_type'($urandom_range(0, 7)));
      no_idle = 1'b1;
      repeat (BURST_PIXELS) send_pixel(random_gray());
      end_burst();
      @(posedge clock);
      while (pending_colors.size() != 0)
         @(posedge clock);
      no_idle = 1'b0;
   endtask

   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = ppm_pkg::PM_GRAY;
      req_if.valid = 1'b0;
      req_if.gray  = '0;
      rsp_if.ready = 1'b0;
      active_mode  = ppm_pkg::PM_GRAY;
      no_idle      = 1'b0;
      ready_hold   = 0;
      idle_cycles  = 0;
      error_count  = 0;
      pixels_sent  = 0;
      colors_checked = 0;
      palette_writes = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_mode();
      test_code_extremes();
      test_hot_ramps();
      test_rainbow_sectors();
      test_bone_copper();
      test_random_palettes();
      test_full_rate();

      // drain, then allow the pipeline to settle
      end_burst();
      @(posedge clock);
      while (pending_colors.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d gray pixels through all eight palettes (%0d palette writes).",
               pixels_sent, palette_writes);
      $display("Checked %0d color words, %0d field errors.", colors_checked, error_count);
      if (error_count == 0)
         $display("pseudocolor_palette_mapper: match");
      else
         $display("pseudocolor_palette_mapper: mismatch");
      $finish;
   end

endmodule

// ===== pseudocolor_palette_mapper.f =====
hdl/ppm_pkg.sv
hdl/ppm_req_if.sv
hdl/ppm_rsp_if.sv
hdl/ppm_ram.sv
hdl/ppm_palette_gen.sv
hdl/pseudocolor_palette_mapper.sv
sim/pseudocolor_palette_mapper_tb.sv
